// ===== sv/ean8_pkg.sv =====
// Shared types, constants and pattern table for the EAN-8 column encoder.
package ean8_pkg;

    localparam int MAX_THICKNESS = 4;
    localparam int MOD_W         = 12;  // most modules any one digit can produce
    localparam int MODCNT_W      = 4;
    localparam int TH_W          = 3;
    localparam int REP_W         = 2;
    localparam int COL_W         = 9;
    localparam int DIGIT_W       = 4;
    localparam int POS_W         = 3;

    localparam logic [2:0] GUARD_EDGE   = 3'b101;
    localparam logic [4:0] GUARD_CENTER = 5'b01010;

    localparam logic [POS_W-1:0] POS_FIRST     = 3'd0;
    localparam logic [POS_W-1:0] POS_LEFT_LAST = 3'd3;
    localparam logic [POS_W-1:0] POS_FINAL     = 3'd7;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

    localparam logic [MODCNT_W-1:0] NMOD_PLAIN  = 4'd7;
    localparam logic [MODCNT_W-1:0] NMOD_EDGE   = 4'd10;
    localparam logic [MODCNT_W-1:0] NMOD_CENTER = 4'd12;

    // One digit's worth of work for the column generator.
    typedef struct packed {
        logic [MOD_W-1:0]    mods;       // module colors, first module in the MSB
        logic [MODCNT_W-1:0] nmods;      // number of valid modules
        logic [TH_W-1:0]     th;         // columns per module, 1..MAX_THICKNESS
        logic                last_digit; // this word closes the code
        logic                ok;         // check digit matched
    } desc_t;

    // L (odd parity) patterns; R patterns are the complement.
    function automatic logic [6:0] l_pattern(input logic [DIGIT_W-1:0] d);
        logic [6:0] p;
        case (d)
            4'd0:    p = 7'h0D;
            4'd1:    p = 7'h19;
            4'd2:    p = 7'h13;
            4'd3:    p = 7'h3D;
            4'd4:    p = 7'h23;
            4'd5:    p = 7'h31;
            4'd6:    p = 7'h2F;
            4'd7:    p = 7'h3B;
            4'd8:    p = 7'h37;
            default: p = 7'h0B;
        endcase
        return p;
    endfunction

endpackage

// ===== sv/ean8_ifs.sv =====
// Valid/ready channel interfaces for digit input and column output.
interface ean8_digit_if;
    logic       valid;
    logic       ready;
    logic [3:0] digit;

    modport source (output valid, output digit, input ready);
    modport sink   (input valid, input digit, output ready);
endinterface

interface ean8_column_if;
    logic       valid;
    logic       ready;
    logic       bar_black;
    logic [8:0] column_index;
    logic       run_last;
    logic       code_done;
    logic       check_ok;

    modport source (output valid, output bar_black, output column_index, output run_last,
                    output code_done, output check_ok, input ready);
    modport sink   (input valid, input bar_black, input column_index, input run_last,
                    input code_done, input check_ok, output ready);
endinterface

// ===== sv/ean8_front.sv =====
// Front end: accepts digits, tracks position and checksum, builds module descriptors.
module ean8_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ean8_pkg::TH_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ean8_pkg::DIGIT_W-1:0] in_digit,
    output logic                        push_valid,
    input  logic                        push_ready,
    output ean8_pkg::desc_t             push_desc
);

    logic [ean8_pkg::TH_W-1:0]  th_cfg_reg;
    logic [ean8_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [3:0]                 sum_reg, sum_next;

    logic [ean8_pkg::DIGIT_W-1:0] d_sat;
    logic [6:0]                   lpat, pat;
    logic [4:0]                   prod;
    logic [5:0]                   acc;
    logic [3:0]                   acc_mod;
    logic [3:0]                   check;
    logic [ean8_pkg::TH_W-1:0]    th_eff;
    logic                         last_digit;
    logic                         accept;

    assign accept     = in_valid && push_ready;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    assign d_sat      = (in_digit > ean8_pkg::DIGIT_MAX) ? ean8_pkg::DIGIT_MAX : in_digit;
    assign lpat       = ean8_pkg::l_pattern(d_sat);
    assign pat        = pos_reg[2] ? ~lpat : lpat;
    assign last_digit = (pos_reg == ean8_pkg::POS_FINAL);

    // weight 3 on even positions, 1 on odd
    assign prod = pos_reg[0] ? {1'b0, d_sat} : ({1'b0, d_sat} + {d_sat, 1'b0});
    assign acc  = {2'b00, sum_reg} + {1'b0, prod};

    always_comb
    begin
        if (acc >= 6'd30)
            acc_mod = 4'(acc - 6'd30);
        else if (acc >= 6'd20)
            acc_mod = 4'(acc - 6'd20);
        else if (acc >= 6'd10)
            acc_mod = 4'(acc - 6'd10);
        else
            acc_mod = acc[3:0];
    end

    assign check = (sum_reg == 4'd0) ? 4'd0 : (4'd10 - sum_reg);

    always_comb
    begin
        if (th_cfg_reg == '0)
            th_eff = ean8_pkg::TH_W'(1);
        else if (th_cfg_reg > ean8_pkg::TH_W'(ean8_pkg::MAX_THICKNESS))
            th_eff = ean8_pkg::TH_W'(ean8_pkg::MAX_THICKNESS);
        else
            th_eff = th_cfg_reg;
    end

    always_comb
    begin
        push_desc.th         = th_eff;
        push_desc.last_digit = last_digit;
        push_desc.ok         = last_digit && (check == d_sat);
        case (pos_reg)
            ean8_pkg::POS_FIRST:
            begin
                push_desc.mods  = {ean8_pkg::GUARD_EDGE, pat, 2'b00};
                push_desc.nmods = ean8_pkg::NMOD_EDGE;
            end
            ean8_pkg::POS_LEFT_LAST:
            begin
                push_desc.mods  = {pat, ean8_pkg::GUARD_CENTER};
                push_desc.nmods = ean8_pkg::NMOD_CENTER;
            end
            ean8_pkg::POS_FINAL:
            begin
                push_desc.mods  = {pat, ean8_pkg::GUARD_EDGE, 2'b00};
                push_desc.nmods = ean8_pkg::NMOD_EDGE;
            end
            default:
            begin
                push_desc.mods  = {pat, 5'b00000};
                push_desc.nmods = ean8_pkg::NMOD_PLAIN;
            end
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        if (accept)
        begin
            if (last_digit)
            begin
                pos_next = '0;
                sum_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 3'd1;
                sum_next = acc_mod;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_cfg_reg <= ean8_pkg::TH_W'(1);
            pos_reg    <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                th_cfg_reg <= cfg_wdata;
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

endmodule

// ===== sv/ean8_fifo.sv =====
// Two-entry descriptor queue between front end and column generator.
module ean8_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  ean8_pkg::desc_t push_desc,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ean8_pkg::desc_t pop_desc
);

    ean8_pkg::desc_t entry_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/ean8_back.sv =====
// Back end: expands descriptors into one column per cycle unless out_ready stalls it, behind an output register.
module ean8_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  ean8_pkg::desc_t           pop_desc,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_bar_black,
    output logic [ean8_pkg::COL_W-1:0] out_column_index,
    output logic                      out_run_last,
    output logic                      out_code_done,
    output logic                      out_check_ok
);

    logic                          busy_reg, busy_next;
    logic [ean8_pkg::MOD_W-1:0]    shift_reg, shift_next;
    logic [ean8_pkg::MODCNT_W-1:0] left_reg, left_next;
    logic [ean8_pkg::REP_W-1:0]    rep_reg, rep_next;
    logic [ean8_pkg::TH_W-1:0]     th_reg, th_next;
    logic                          last_digit_reg, last_digit_next;
    logic                          ok_reg, ok_next;
    logic [ean8_pkg::COL_W-1:0]    col_reg, col_next;

    logic                          ovalid_reg, ovalid_next;
    logic                          obar_reg, obar_next;
    logic [ean8_pkg::COL_W-1:0]    ocol_reg, ocol_next;
    logic                          orun_reg, orun_next;
    logic                          odone_reg, odone_next;
    logic                          ook_reg, ook_next;

    logic advance, rep_end, col_last, load;

    assign advance  = busy_reg && (!ovalid_reg || out_ready);
    assign rep_end  = (rep_reg == ean8_pkg::REP_W'(th_reg - ean8_pkg::TH_W'(1)));
    assign col_last = rep_end && (left_reg == ean8_pkg::MODCNT_W'(1));
    assign load     = pop_valid && (!busy_reg || (advance && col_last));
    assign pop_ready = !busy_reg || (advance && col_last);

    always_comb
    begin
        busy_next       = busy_reg;
        shift_next      = shift_reg;
        left_next       = left_reg;
        rep_next        = rep_reg;
        th_next         = th_reg;
        last_digit_next = last_digit_reg;
        ok_next         = ok_reg;
        col_next        = col_reg;

        if (advance)
        begin
            col_next = (col_last && last_digit_reg) ? '0 : col_reg + 9'd1;
            if (rep_end)
            begin
                rep_next   = '0;
                shift_next = {shift_reg[ean8_pkg::MOD_W-2:0], 1'b0};
                left_next  = left_reg - 4'd1;
            end
            else
            begin
                rep_next = rep_reg + 2'd1;
            end
            if (col_last)
                busy_next = 1'b0;
        end

        if (load)
        begin
            busy_next       = 1'b1;
            shift_next      = pop_desc.mods;
            left_next       = pop_desc.nmods;
            rep_next        = '0;
            th_next         = pop_desc.th;
            last_digit_next = pop_desc.last_digit;
            ok_next         = pop_desc.ok;
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        obar_next   = obar_reg;
        ocol_next   = ocol_reg;
        orun_next   = orun_reg;
        odone_next  = odone_reg;
        ook_next    = ook_reg;
        if (advance)
        begin
            ovalid_next = 1'b1;
            obar_next   = shift_reg[ean8_pkg::MOD_W-1];
            ocol_next   = col_reg;
            orun_next   = col_last;
            odone_next  = col_last && last_digit_reg;
            ook_next    = col_last && last_digit_reg && ok_reg;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg      <= shift_next;
        left_reg       <= left_next;
        rep_reg        <= rep_next;
        th_reg         <= th_next;
        last_digit_reg <= last_digit_next;
        ok_reg         <= ok_next;
        obar_reg       <= obar_next;
        ocol_reg       <= ocol_next;
        orun_reg       <= orun_next;
        odone_reg      <= odone_next;
        ook_reg        <= ook_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            col_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            col_reg    <= col_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid        = ovalid_reg;
    assign out_bar_black    = obar_reg;
    assign out_column_index = ocol_reg;
    assign out_run_last     = orun_reg;
    assign out_code_done    = odone_reg;
    assign out_check_ok     = ook_reg;

endmodule

// ===== sv/ean8_barcode_module_encoder.sv =====
// Top level of the EAN-8 bar image column encoder.
// A descriptor passes the queue register, the generator state and the output register.
// Throughput: one column word per cycle unless columns.ready stalls; a digit gives
//   modules x thickness columns (7, 10 or 12, thickness 1..4) from the single generator.
// The front end takes a new digit while the generator still works on earlier ones.
// Reset (rst_n low, asynchronous): thickness 1, position, checksum and column count zero.
module ean8_barcode_module_encoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ean8_pkg::TH_W-1:0]  cfg_wdata,
    ean8_digit_if.sink                 digits,
    ean8_column_if.source              columns
);

    // Descriptor hand-off between the front end and the queue.
    logic            push_valid, push_ready;
    ean8_pkg::desc_t push_desc;

    // Queue output into the column generator.
    logic            pop_valid, pop_ready;
    ean8_pkg::desc_t pop_desc;

    // Front end: saturate the digit, pick L or R pattern, wrap in guards, update checksum.
    ean8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (digits.valid),
        .in_ready   (digits.ready),
        .in_digit   (digits.digit),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    // Hold up to two pending digit descriptors so each side can stall on its own.
    ean8_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    // Back end: repeat each module thickness times, advance the column counter,
    // and flag the last column of each digit and of the whole code.
    ean8_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_desc         (pop_desc),
        .out_valid        (columns.valid),
        .out_ready        (columns.ready),
        .out_bar_black    (columns.bar_black),
        .out_column_index (columns.column_index),
        .out_run_last     (columns.run_last),
        .out_code_done    (columns.code_done),
        .out_check_ok     (columns.check_ok)
    );

endmodule

// ===== sv/ean8_checker.sv =====
// Port-level assertions for the EAN-8 encoder, bound to the top level.
module ean8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       bar_black,
    input logic [8:0] column_index,
    input logic       run_last,
    input logic       code_done,
    input logic       check_ok
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(column_index)
            && $stable(bar_black) && $stable(run_last))
        else $error("column word changed while stalled");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && code_done |-> run_last)
        else $error("code_done without run_last");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && check_ok |-> code_done)
        else $error("check_ok outside final column");

    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=>
            out_valid && (column_index == $past(column_index) + 9'd1))
        else $error("columns of one digit not contiguous");

endmodule

bind ean8_barcode_module_encoder ean8_checker u_ean8_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (columns.valid),
    .out_ready    (columns.ready),
    .bar_black    (columns.bar_black),
    .column_index (columns.column_index),
    .run_last     (columns.run_last),
    .code_done    (columns.code_done),
    .check_ok     (columns.check_ok)
);
